@@ rtl/crb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_pkg: shared types for the chunk reorder buffer
// Item layouts, result status codes and the job passed from front to back.
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int unsigned CHUNK_W = 6;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned SLOTS_W = 64;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_HELD     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_DUP      = 2'd3
  } crb_status_e;

  typedef enum logic [1:0] {
    JOB_REJECT  = 2'd0,
    JOB_HOLD    = 2'd1,
    JOB_RELEASE = 2'd2
  } crb_kind_e;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_number;
    logic [DATA_W-1:0]  payload;
  } crb_chunk_t;

  typedef struct packed {
    crb_status_e        status;
    logic [CHUNK_W-1:0] out_chunk_number;
    logic [DATA_W-1:0]  out_payload;
    logic               transfer_done;
    logic               last;
  } crb_result_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    crb_kind_e          kind;
    crb_status_e        status;
    logic               clear;
    logic [TOTAL_W-1:0] total;
    logic [CHUNK_W-1:0] chunk_number;
    logic [DATA_W-1:0]  payload;
  } crb_job_t;

  // Sequence state the back reports to the front.
  typedef struct packed {
    logic               retire;
    logic [TOTAL_W-1:0] next_expected;
    logic [SLOTS_W-1:0] slot_valid;
  } crb_state_t;

endpackage
`default_nettype wire

@@ rtl/crb_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_stream_if: valid/ready stream channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface crb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/crb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_front: item intake and classification
// Holds the total register, checks each item against the sequence state and
// pushes a job to the queue. One item is in flight until the back retires it.
// ----------------------------------------------------------------------------
module crb_front
  import crb_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS    = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TOTAL_W-1:0] cfg_wdata_i,
  crb_stream_if.sink              chunk_i,
  input  wire crb_state_t         state_i,
  output crb_job_t                job_o,
  output logic                    job_valid_o,
  input  wire logic               job_ready_i
);

  localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(MAX_CHUNKS);
  localparam logic [DATA_W-1:0]  PayMask  = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_WIDTH);

  logic [TOTAL_W-1:0] total_q, total_d;
  logic               busy_q, busy_d;
  logic [TOTAL_W-1:0] eff_total;
  logic [TOTAL_W-1:0] next_cur;
  logic               restart;
  logic               slot_hit;
  logic               accept;

  always_comb begin
    if (total_q == '0) begin
      eff_total = TOTAL_W'(1);
    end else if (total_q > MaxTotal) begin
      eff_total = MaxTotal;
    end else begin
      eff_total = total_q;
    end
  end

  // A finished or shortened transfer restarts before this item is judged.
  assign restart  = (state_i.next_expected >= eff_total);
  assign next_cur = restart ? '0 : state_i.next_expected;
  assign slot_hit = !restart && state_i.slot_valid[chunk_i.data.chunk_number];

  assign chunk_i.ready = !busy_q && job_ready_i;
  assign accept        = chunk_i.valid && chunk_i.ready;
  assign job_valid_o   = accept;

  always_comb begin
    job_o.clear        = restart;
    job_o.total        = eff_total;
    job_o.chunk_number = chunk_i.data.chunk_number;
    job_o.payload      = chunk_i.data.payload & PayMask;
    if ({1'b0, chunk_i.data.chunk_number} >= eff_total) begin
      job_o.kind   = JOB_REJECT;
      job_o.status = ST_RANGE;
    end else if (({1'b0, chunk_i.data.chunk_number} < next_cur) || slot_hit) begin
      job_o.kind   = JOB_REJECT;
      job_o.status = ST_DUP;
    end else if ({1'b0, chunk_i.data.chunk_number} == next_cur) begin
      job_o.kind   = JOB_RELEASE;
      job_o.status = ST_RELEASED;
    end else begin
      job_o.kind   = JOB_HOLD;
      job_o.status = ST_HELD;
    end
  end

  always_comb begin
    total_d = cfg_we_i ? cfg_wdata_i : total_q;
    busy_d  = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (state_i.retire) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_W'(1);
      busy_q  <= 1'b0;
    end else begin
      total_q <= total_d;
      busy_q  <= busy_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_queue: two-entry job queue
// Decouples the intake from the release engine.
// ----------------------------------------------------------------------------
module crb_queue
  import crb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire crb_job_t push_data_i,
  input  wire logic     push_i,
  output logic          push_ready_o,
  output crb_job_t      pop_data_o,
  output logic          pop_valid_o,
  input  wire logic     pop_i
);

  crb_job_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/crb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crb_back: slot store and in-order release engine
// Owns the slot memory, the slot valid bits and the next expected number.
// One job at a time; drains contiguous slots, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module crb_back
  import crb_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS    = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire crb_job_t job_i,
  input  wire logic     job_valid_i,
  output logic          job_ready_o,
  output crb_state_t    state_o,
  crb_stream_if.source  result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                   state_q, state_d;
  logic [TOTAL_W-1:0]       next_q, next_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic [MAX_CHUNKS-1:0]    valid_q, valid_d;
  logic                     out_valid_q, out_valid_d;
  crb_result_t              out_q, out_d;

  logic [PAYLOAD_WIDTH-1:0] mem [MAX_CHUNKS];
  logic [PAYLOAD_WIDTH-1:0] rdata_q;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;

  logic                     out_free;
  logic                     retire;
  logic [MAX_CHUNKS-1:0]    valid_cur;
  logic [TOTAL_W-1:0]       next_cur;
  logic [TOTAL_W-1:0]       nxt_job;
  logic                     more_job;
  logic                     done_job;
  logic [TOTAL_W-1:0]       nxt_rd;
  logic                     more_rd;
  logic                     done_rd;

  assign out_free    = !out_valid_q || result_o.ready;
  assign job_ready_o = (state_q == S_IDLE) && out_free;

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  assign state_o.retire        = retire;
  assign state_o.next_expected = next_q;
  assign state_o.slot_valid    = SLOTS_W'(valid_q);

  // The job's clear flag restarts the transfer before the job itself.
  assign valid_cur = job_i.clear ? '0 : valid_q;
  assign next_cur  = job_i.clear ? '0 : next_q;
  assign mem_waddr = job_i.chunk_number[IDX_W-1:0];

  assign nxt_job  = {1'b0, job_i.chunk_number} + TOTAL_W'(1);
  assign done_job = (nxt_job == job_i.total);
  assign more_job = (nxt_job < job_i.total) && valid_cur[nxt_job[IDX_W-1:0]];

  assign nxt_rd  = next_q + TOTAL_W'(1);
  assign done_rd = (nxt_rd == total_q);
  assign more_rd = (nxt_rd < total_q) && valid_q[nxt_rd[IDX_W-1:0]];

  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    total_d     = total_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    retire      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i && out_free) begin
          total_d                = job_i.total;
          valid_d                = valid_cur;
          next_d                 = next_cur;
          out_valid_d            = 1'b1;
          out_d.out_chunk_number = job_i.chunk_number;
          out_d.out_payload      = '0;
          out_d.transfer_done    = 1'b0;
          out_d.last             = 1'b1;
          case (job_i.kind)
            JOB_HOLD: begin
              mem_we             = 1'b1;
              valid_d[mem_waddr] = 1'b1;
              out_d.status       = ST_HELD;
              retire             = 1'b1;
            end
            JOB_RELEASE: begin
              // The arriving chunk is the expected one and leaves at once.
              out_d.status        = ST_RELEASED;
              out_d.out_payload   = job_i.payload;
              out_d.transfer_done = done_job;
              out_d.last          = !more_job;
              if (done_job) begin
                valid_d = '0;
                next_d  = '0;
                retire  = 1'b1;
              end else begin
                next_d = nxt_job;
                if (more_job) begin
                  rd_en            = 1'b1;
                  rd_addr          = nxt_job[IDX_W-1:0];
                  valid_d[rd_addr] = 1'b0;
                  state_d          = S_READ;
                end else begin
                  retire = 1'b1;
                end
              end
            end
            default: begin
              out_d.status = job_i.status;
              retire       = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = ST_RELEASED;
          out_d.out_chunk_number = next_q[CHUNK_W-1:0];
          out_d.out_payload      = DATA_W'(rdata_q);
          out_d.transfer_done    = done_rd;
          out_d.last             = !more_rd;
          if (done_rd) begin
            valid_d = '0;
            next_d  = '0;
            retire  = 1'b1;
            state_d = S_IDLE;
          end else begin
            next_d = nxt_rd;
            if (more_rd) begin
              rd_en            = 1'b1;
              rd_addr          = nxt_rd[IDX_W-1:0];
              valid_d[rd_addr] = 1'b0;
            end else begin
              retire  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= job_i.payload[PAYLOAD_WIDTH-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_q      <= '0;
      total_q     <= TOTAL_W'(1);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      total_q     <= total_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

`ifndef SYNTH
  // The front only sends a release job for the chunk the sequence expects.
  a_release_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o && job_i.kind == JOB_RELEASE)
      |-> ({1'b0, job_i.chunk_number} == next_cur))
    else $error("release job does not match the expected chunk");

  a_next_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= TOTAL_W'(MAX_CHUNKS))
    else $error("next expected number beyond slot count");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.transfer_done) |-> out_q.last)
    else $error("transfer end not flagged as last result of its item");

  a_retire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |=> (state_q == S_IDLE))
    else $error("engine busy after retiring its job");
`endif

endmodule
`default_nettype wire

@@ rtl/chunk_reorder_buffer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_reorder_buffer_top: reorder buffer for numbered chunks
// Releases chunks that arrive in any order strictly in chunk order.
// ----------------------------------------------------------------------------
// Usage:
//   chunk_i carries one arriving chunk (number and payload) per item;
//   result_o carries one result item per released chunk, or a single held,
//   out of range or duplicate result when the arrival releases nothing.
//   cfg_we_i/cfg_wdata_i write the transfer's chunk count while idle.
// Timing:
//   An accepted item passes through the job queue, and its first result is
//   held in the release engine's output register. Each further released
//   chunk is paced by the registered read of the slot memory. An item
//   occupies the block until it has retired; only then is the next taken.
// Reset:
//   All slots are empty, the next expected number is zero and the chunk
//   count is one. No memory clearing pass is needed.
// Backpressure:
//   When result_o is stalled the release engine holds its output register
//   and stops draining; chunk_i drops ready until the item has retired.
// ----------------------------------------------------------------------------
module chunk_reorder_buffer_top
  import crb_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS    = 64,
  parameter int unsigned PAYLOAD_WIDTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TOTAL_W-1:0] cfg_wdata_i,
  crb_stream_if.sink              chunk_i,
  crb_stream_if.source            result_o
);

  crb_job_t   push_job;
  logic       push_valid;
  logic       push_ready;
  crb_job_t   pop_job;
  logic       pop_valid;
  logic       pop_ready;
  crb_state_t seq_state;

  crb_front #(
    .MAX_CHUNKS    (MAX_CHUNKS),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .chunk_i     (chunk_i),
    .state_i     (seq_state),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  crb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop_ready)
  );

  crb_back #(
    .MAX_CHUNKS    (MAX_CHUNKS),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .state_o     (seq_state),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire
